@@ src/deq_pkg.sv @@
// Shared definitions for the double-ended queue: command codes, cell control
// bundle and default sizes. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEQ_DEPTH      = 16;
  localparam int DEQ_WORD_WIDTH = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } deq_cmd_t;

  // Broadcast to every cell for one accepted item
  typedef struct packed {
    logic shift_in;   // push front: whole row moves one cell toward the back
    logic shift_out;  // pop front: whole row moves one cell toward the front
    logic append;     // push back: first empty cell loads the word
    logic remove;     // pop back: last occupied cell drops its entry
  } deq_ctl_t;

endpackage

@@ src/deq_cell.sv @@
// One storage cell of the queue row: a word and its valid bit.
// Trades data with its two neighbors under the shared control bundle.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell
  import deq_pkg::*;
#(
  parameter int WORD_WIDTH = DEQ_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  deq_ctl_t              ctl,
  input  logic [WORD_WIDTH-1:0] in_word,
  input  logic [WORD_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [WORD_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [WORD_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  is_last
);

  logic [WORD_WIDTH-1:0] data_r, data_nxt;
  logic                  valid_r, valid_nxt;

  assign is_last = valid_r & ~right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.shift_in) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctl.shift_out) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctl.append && !valid_r && left_valid) begin
      data_nxt  = in_word;
      valid_nxt = 1'b1;
    end else if (ctl.remove && is_last) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

@@ src/double_ended_queue_core.sv @@
// Double-ended queue built as a row of cells, front held in cell 0.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the front
// word comes from cell 0, the back word from an AND-OR across the cells' last-entry flags.
// Reset clears all cell valid bits, the count and the output valid; no
// clearing pass is needed. Depends on deq_pkg and deq_cell.
`timescale 1ns / 1ps

module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int WORD_WIDTH = DEQ_WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_command,
  input  logic [WORD_WIDTH-1:0]        in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [WORD_WIDTH-1:0]        out_result_value,
  output logic                         out_has_value,
  output logic                         out_push_refused,
  output logic [$clog2(DEPTH+1)-1:0]   out_occupancy,
  output logic                         out_is_empty
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_last;
  logic [WORD_WIDTH-1:0] cell_data [DEPTH];

  logic                  in_fire;
  logic                  full, empty;
  deq_ctl_t              ctl;
  logic                  found, refused;
  logic [WORD_WIDTH-1:0] res_word;
  logic [WORD_WIDTH-1:0] back_word;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] res_word_r;
  logic                  found_r, refused_r, empty_r;
  logic [CNT_W-1:0]      occ_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign full     = cell_valid[DEPTH-1];
  assign empty    = ~cell_valid[0];

  // Back end: exactly one cell flags itself last when the row is non-empty
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | ({WORD_WIDTH{cell_last[i]}} & cell_data[i]);
    end
  end

  always_comb begin
    ctl      = '0;
    found    = 1'b0;
    refused  = 1'b0;
    res_word = '0;
    cnt_nxt  = cnt_r;
    case (deq_cmd_t'(in_command))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          refused = 1'b1;
        end else begin
          ctl.shift_in = (deq_cmd_t'(in_command) == CMD_PUSH_FRONT);
          ctl.append   = (deq_cmd_t'(in_command) == CMD_PUSH_BACK);
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (!empty) begin
          found         = 1'b1;
          res_word      = cell_data[0];
          ctl.shift_out = (deq_cmd_t'(in_command) == CMD_POP_FRONT);
          if (deq_cmd_t'(in_command) == CMD_POP_FRONT) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (!empty) begin
          found      = 1'b1;
          res_word   = back_word;
          ctl.remove = (deq_cmd_t'(in_command) == CMD_POP_BACK);
          if (deq_cmd_t'(in_command) == CMD_POP_BACK) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      ctl     = '0;
      cnt_nxt = cnt_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] l_data, r_data;
    logic                  l_valid, r_valid;
    if (i == 0) begin : g_head
      assign l_data  = in_value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == DEPTH-1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    deq_cell #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .in_word     (in_value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .is_last     (cell_last[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_word_r <= res_word;
      found_r    <= found;
      refused_r  <= refused;
      occ_r      <= cnt_nxt;
      empty_r    <= (cnt_nxt == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_word_r;
  assign out_has_value    = found_r;
  assign out_push_refused = refused_r;
  assign out_occupancy    = occ_r;
  assign out_is_empty     = empty_r;

  // Count tracks the occupied cells
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(cell_valid)))
    else $error("count differs from occupied cells");

  // Occupied cells form one run starting at cell 0
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells not packed toward the front");

  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_last))
    else $error("more than one cell flags itself last");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && refused_r))
    else $error("item both returned a word and refused a push");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full && (in_command == CMD_PUSH_FRONT || in_command == CMD_PUSH_BACK))
    |=> (cnt_r == $past(cnt_r)))
    else $error("refused push changed the count");

endmodule

@@ verif/double_ended_queue_checker.sv @@
// Checker for the double-ended queue: watches both channels, keeps its own
// copy of the queue contents, predicts each result and compares it.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module double_ended_queue_checker
  import deq_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [2:0]                       in_command,
  input  logic [DEQ_WORD_WIDTH-1:0]        in_value,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [DEQ_WORD_WIDTH-1:0]        out_result_value,
  input  logic                             out_has_value,
  input  logic                             out_push_refused,
  input  logic [$clog2(DEQ_DEPTH+1)-1:0]   out_occupancy,
  input  logic                             out_is_empty,
  output int                               fail_count,
  output int                               results_pending
);

  localparam int OCC_W = $clog2(DEQ_DEPTH + 1);

  typedef struct packed {
    logic [DEQ_WORD_WIDTH-1:0] word;
    logic                      found;
    logic                      refused;
    logic [OCC_W-1:0]          occupancy;
    logic                      empty;
  } deq_result_t;

  logic [DEQ_WORD_WIDTH-1:0] queue_words [DEQ_DEPTH];
  int                        front_slot;
  int                        back_slot;   // one past the back element
  int                        held;
  deq_result_t               expected_results [$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
    front_slot      = 0;
    back_slot       = 0;
    held            = 0;
  end

  function automatic int next_slot(int idx);
    return (idx + 1 == DEQ_DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int prev_slot(int idx);
    return (idx == 0) ? DEQ_DEPTH - 1 : idx - 1;
  endfunction

  // Applies one command to the local queue copy and returns its result
  function automatic deq_result_t predict_command(logic [2:0] cmd,
                                                  logic [DEQ_WORD_WIDTH-1:0] word);
    deq_result_t res;
    res = '0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (held == DEQ_DEPTH) begin
          res.refused = 1'b1;
        end else begin
          front_slot              = prev_slot(front_slot);
          queue_words[front_slot] = word;
          held++;
        end
      end
      CMD_PUSH_BACK: begin
        if (held == DEQ_DEPTH) begin
          res.refused = 1'b1;
        end else begin
          queue_words[back_slot] = word;
          back_slot              = next_slot(back_slot);
          held++;
        end
      end
      CMD_POP_FRONT: begin
        if (held != 0) begin
          res.word   = queue_words[front_slot];
          res.found  = 1'b1;
          front_slot = next_slot(front_slot);
          held--;
        end
      end
      CMD_POP_BACK: begin
        if (held != 0) begin
          back_slot = prev_slot(back_slot);
          res.word  = queue_words[back_slot];
          res.found = 1'b1;
          held--;
        end
      end
      CMD_PEEK_FRONT: begin
        if (held != 0) begin
          res.word  = queue_words[front_slot];
          res.found = 1'b1;
        end
      end
      CMD_PEEK_BACK: begin
        if (held != 0) begin
          res.word  = queue_words[prev_slot(back_slot)];
          res.found = 1'b1;
        end
      end
      default: ;  // unused codes leave the queue alone
    endcase
    res.occupancy = OCC_W'(held);
    res.empty     = (held == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t deque check failed on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_results
    deq_result_t want;
    if (rst_n) begin
      // a result can never belong to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no command pending", out_result_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_result_value !== want.word)
            report_mismatch("result_value", out_result_value, want.word);
          if (out_has_value !== want.found)
            report_mismatch("has_value", out_has_value, want.found);
          if (out_push_refused !== want.refused)
            report_mismatch("push_refused", out_push_refused, want.refused);
          if (out_occupancy !== want.occupancy)
            report_mismatch("occupancy", out_occupancy, want.occupancy);
          if (out_is_empty !== want.empty)
            report_mismatch("is_empty", out_is_empty, want.empty);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_command(in_command, in_value));
      results_pending = expected_results.size();
    end
  end

endmodule

@@ verif/double_ended_queue_core_tb.sv @@
// Testbench top for double_ended_queue_core: drives command items with random
// gaps and stalls, and gives the verdict from double_ended_queue_checker.
// Depends on deq_pkg, the block and the checker.
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  localparam int         OCC_W          = $clog2(DEQ_DEPTH + 1);
  localparam int         COMMAND_COUNT  = 650;
  localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
  localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_command = '0;
  logic [DEQ_WORD_WIDTH-1:0] in_value   = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b1;
  logic [DEQ_WORD_WIDTH-1:0] out_result_value;
  logic                      out_has_value;
  logic                      out_push_refused;
  logic [OCC_W-1:0]          out_occupancy;
  logic                      out_is_empty;

  int fail_count;
  int results_pending;
  int commands_sent  = 0;
  bit sender_quiet   = 1'b0;

  double_ended_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_has_value    (out_has_value),
    .out_push_refused (out_push_refused),
    .out_occupancy    (out_occupancy),
    .out_is_empty     (out_is_empty)
  );

  double_ended_queue_checker deq_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_has_value    (out_has_value),
    .out_push_refused (out_push_refused),
    .out_occupancy    (out_occupancy),
    .out_is_empty     (out_is_empty),
    .fail_count       (fail_count),
    .results_pending  (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DEQ_WORD_WIDTH-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return DEQ_WORD_WIDTH'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_command(logic [2:0] cmd, logic [DEQ_WORD_WIDTH-1:0] word);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command <= cmd;
    in_value   <= word;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    commands_sent++;
  endtask

  initial begin : result_sink
    int  hold;
    int  span;
    bit  quiet;
    span  = 0;
    quiet = 1'b0;
    @(negedge clk);
    forever begin
      if (span == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        span  = $urandom_range(10, 50);
      end
      span--;
      hold = quiet ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [2:0]                cmd;
    logic [DEQ_WORD_WIDTH-1:0] word;
    int                        burst_len;
    int                        push_pct;
    int                        roll;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reads on an empty queue return nothing; unused codes do nothing
    send_command(CMD_POP_FRONT, random_word());
    send_command(CMD_POP_BACK, random_word());
    send_command(CMD_PEEK_FRONT, random_word());
    send_command(CMD_PEEK_BACK, random_word());
    send_command(CMD_RESERVED_6, random_word());
    send_command(CMD_RESERVED_7, random_word());

    // fill from both ends, then push into a full store
    for (int i = 0; i < DEQ_DEPTH; i++) begin
      word = (i == 0) ? '0 : (i == 1) ? '1 : DEQ_WORD_WIDTH'($urandom);
      send_command(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, word);
    end
    send_command(CMD_PUSH_FRONT, random_word());
    send_command(CMD_PUSH_BACK, random_word());
    send_command(CMD_PEEK_FRONT, random_word());
    send_command(CMD_PEEK_BACK, random_word());
    send_command(CMD_POP_FRONT, random_word());
    send_command(CMD_POP_BACK, random_word());

    // bursts that lean toward filling, draining or holding level
    while (commands_sent < COMMAND_COUNT) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 20;
        default: push_pct = 45;
      endcase
      sender_quiet = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          cmd = $urandom_range(0, 1) ? CMD_RESERVED_7 : CMD_RESERVED_6;
        end else if (roll < 3 + push_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          case ($urandom_range(0, 5))
            0, 1:    cmd = CMD_POP_FRONT;
            2, 3:    cmd = CMD_POP_BACK;
            4:       cmd = CMD_PEEK_FRONT;
            default: cmd = CMD_PEEK_BACK;
          endcase
        end
        send_command(cmd, random_word());
      end
    end
    in_valid <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
